// File: hdl/aas_pkg.sv
// Package for the area-averaging image scaler: sizes, state and command
// codes, and the control/status bundles between the controller and datapath.
// No dependencies.
`default_nettype none
package aas_pkg;

  localparam int unsigned MaxRows = 256;
  localparam int unsigned MaxCols = 256;
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned AddrW   = RowW + ColW;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned NumW    = 25;
  localparam int unsigned DenW    = 17;
  localparam int unsigned CntW    = 5;

  localparam logic [1:0] RegSrcRows = 2'd0;
  localparam logic [1:0] RegSrcCols = 2'd1;
  localparam logic [1:0] RegDstRows = 2'd2;
  localparam logic [1:0] RegDstCols = 2'd3;

  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdCompute = 1'b1;

  localparam logic [2:0] DivYs  = 3'd0;
  localparam logic [2:0] DivYe  = 3'd1;
  localparam logic [2:0] DivXs  = 3'd2;
  localparam logic [2:0] DivXe  = 3'd3;
  localparam logic [2:0] DivRed = 3'd4;
  localparam logic [2:0] DivGrn = 3'd5;
  localparam logic [2:0] DivBlu = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIV_GO, ST_DIV_WAIT, ST_ROW_MUL, ST_ROW_WGT,
    ST_PIX_RD, ST_PIX_WX, ST_PIX_MW, ST_PIX_ACC, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD_IN, DP_DIV_START, DP_DIV_TAKE, DP_ROW_MUL, DP_ROW_WGT,
    DP_PIX_RD, DP_PIX_WX, DP_PIX_MW, DP_PIX_ACC, DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] div_sel;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic outside;
    logic x_last;
    logic y_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/aas_div.sv
// Restoring divider, one quotient bit per cycle, for the scaler datapath.
// Depends on aas_pkg.
`default_nettype none
module aas_div import aas_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic [NumW-1:0]      quo_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] sh_q, sh_d;
  logic [DenW:0]   rem_q, rem_d, trial;
  logic [DenW-1:0] den_q, den_d;

  always_comb begin
    cnt_d = cnt_q;
    sh_d  = sh_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q[DenW-1:0], sh_q[NumW-1]};
    if (start_i) begin
      cnt_d = CntW'(NumW);
      sh_d  = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        sh_d  = {sh_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        sh_d  = {sh_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = sh_q;

endmodule
`default_nettype wire

// File: hdl/aas_dp.sv
// Datapath of the scaler: registers, frame store, overlap weights,
// accumulators and the shared divider. Depends on aas_pkg and aas_div.
`default_nettype none
module aas_dp import aas_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ctl_t            ctl_i,
  output sts_t                 sts_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic            in_cmd_i,
  input  wire logic [39:0]     in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 out_kind_o,
  output logic [23:0]          out_data_o
);

  logic [CfgW-1:0] src_rows_q, src_cols_q, dst_rows_q, dst_cols_q;
  logic [CfgW-1:0] sr, sc, tr, tc;
  logic            cmd_q;
  logic [RowW-1:0] row_q, y_q, ys_q;
  logic [ColW-1:0] col_q, x_q, xs_q;
  logic [CfgW-1:0] ye_q, xe_q;
  logic [17:0]     cy_q, cx_q, py_q, px_q;
  logic [8:0]      wy_q, wx_q;
  logic [16:0]     wgt_q;
  logic [23:0]     pix_q;
  logic [NumW-1:0] acc_q [3];
  logic [7:0]      res_q [3];
  logic            out_valid_q, kind_q;

  logic [23:0]     mem [MaxRows*MaxCols];
  logic [23:0]     mem_rd_q;

  logic [NumW-1:0] div_num, quo;
  logic [DenW-1:0] div_den;
  logic            div_busy;
  logic [17:0]     prod_lo, prod_hi;
  logic [17:0]     y_lo, y_hi, x_lo, x_hi;
  logic [17:0]     cy_n, cx_n;
  logic [7:0]      quo_sat;

  // Zero sizes act as one, oversize sources act as the store size.
  always_comb begin
    sr = (src_rows_q == '0) ? CfgW'(1) :
         (src_rows_q > CfgW'(MaxRows)) ? CfgW'(MaxRows) : src_rows_q;
    sc = (src_cols_q == '0) ? CfgW'(1) :
         (src_cols_q > CfgW'(MaxCols)) ? CfgW'(MaxCols) : src_cols_q;
    tr = (dst_rows_q == '0) ? CfgW'(1) : dst_rows_q;
    tc = (dst_cols_q == '0) ? CfgW'(1) : dst_cols_q;
  end

  always_comb begin
    cy_n    = 18'(sr * row_q);
    cx_n    = 18'(sc * col_q);
    prod_lo = '0;
    prod_hi = '0;
    div_num = '0;
    div_den = '0;
    case (ctl_i.div_sel)
      DivYs: begin
        div_num = NumW'(cy_n);
        div_den = DenW'(tr);
      end
      DivYe: begin
        prod_hi = 18'(sr * ({1'b0, row_q} + 9'd1)) + 18'(tr) - 18'd1;
        div_num = NumW'(prod_hi);
        div_den = DenW'(tr);
      end
      DivXs: begin
        div_num = NumW'(cx_n);
        div_den = DenW'(tc);
      end
      DivXe: begin
        prod_hi = 18'(sc * ({1'b0, col_q} + 9'd1)) + 18'(tc) - 18'd1;
        div_num = NumW'(prod_hi);
        div_den = DenW'(tc);
      end
      DivRed, DivGrn, DivBlu: begin
        prod_lo = 18'(sr * sc);
        div_num = acc_q[2'(ctl_i.div_sel - DivRed)];
        div_den = DenW'(prod_lo);
      end
      default: begin
        div_num = '0;
        div_den = DenW'(1);
      end
    endcase
  end

  aas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.op == DP_DIV_START),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign quo_sat = (quo > NumW'(255)) ? 8'hFF : quo[7:0];

  // Overlap of a source pixel with the output cell, in units of 1/target.
  always_comb begin
    y_lo = (py_q > cy_q) ? py_q : cy_q;
    y_hi = ((py_q + 18'(tr)) < (cy_q + 18'(sr))) ? (py_q + 18'(tr)) : (cy_q + 18'(sr));
    x_lo = (px_q > cx_q) ? px_q : cx_q;
    x_hi = ((px_q + 18'(tc)) < (cx_q + 18'(sc))) ? (px_q + 18'(tc)) : (cx_q + 18'(sc));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rows_q <= CfgW'(256);
      src_cols_q <= CfgW'(256);
      dst_rows_q <= CfgW'(128);
      dst_cols_q <= CfgW'(128);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSrcRows: src_rows_q <= cfg_data_i;
        RegSrcCols: src_cols_q <= cfg_data_i;
        RegDstRows: dst_rows_q <= cfg_data_i;
        RegDstCols: dst_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.op == DP_OUT_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_LOAD_IN && in_cmd_i == CmdWrite) begin
      mem[{in_data_i[7:0], in_data_i[15:8]}] <= in_data_i[39:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_PIX_RD) begin
      mem_rd_q <= mem[{y_q, x_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      DP_LOAD_IN: begin
        cmd_q <= in_cmd_i;
        row_q <= in_data_i[7:0];
        col_q <= in_data_i[15:8];
        for (int c = 0; c < 3; c++) begin
          acc_q[c] <= '0;
          res_q[c] <= '0;
        end
      end
      DP_DIV_START: begin
        if (ctl_i.div_sel == DivYs) cy_q <= cy_n;
        if (ctl_i.div_sel == DivXs) cx_q <= cx_n;
      end
      DP_DIV_TAKE: begin
        case (ctl_i.div_sel)
          DivYs: ys_q <= quo[RowW-1:0];
          DivYe: ye_q <= (quo > NumW'(sr)) ? sr : quo[CfgW-1:0];
          DivXs: xs_q <= quo[ColW-1:0];
          DivXe: begin
            xe_q <= (quo > NumW'(sc)) ? sc : quo[CfgW-1:0];
            y_q  <= ys_q;
            x_q  <= xs_q;
          end
          DivRed, DivGrn, DivBlu: res_q[2'(ctl_i.div_sel - DivRed)] <= quo_sat;
          default: ;
        endcase
      end
      DP_ROW_MUL: py_q <= 18'(y_q * tr);
      DP_ROW_WGT: wy_q <= (y_hi > y_lo) ? 9'(y_hi - y_lo) : '0;
      DP_PIX_RD:  px_q <= 18'(x_q * tc);
      DP_PIX_WX: begin
        wx_q  <= (x_hi > x_lo) ? 9'(x_hi - x_lo) : '0;
        pix_q <= mem_rd_q;
      end
      DP_PIX_MW: wgt_q <= 17'(wy_q * wx_q);
      DP_PIX_ACC: begin
        // Zero-weight pixels are left out so unwritten data cannot leak in.
        if (wgt_q != '0) begin
          for (int c = 0; c < 3; c++) begin
            acc_q[c] <= acc_q[c] + NumW'(wgt_q * pix_q[8*c +: 8]);
          end
        end
        if (sts_o.x_last) begin
          x_q <= xs_q;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      DP_OUT_LOAD: begin
        kind_q     <= cmd_q;
        out_data_o <= {res_q[2], res_q[1], res_q[0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.div_busy = div_busy;
    sts_o.outside  = ({1'b0, row_q} >= tr) || ({1'b0, col_q} >= tc);
    sts_o.x_last   = (({1'b0, x_q} + 9'd1) == xe_q);
    sts_o.y_last   = (({1'b0, y_q} + 9'd1) == ye_q);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;

endmodule
`default_nettype wire

// File: hdl/aas_ctrl.sv
// Controller state machine of the scaler: sequences divisions, the source
// walk and the result hand-off. Depends on aas_pkg.
`default_nettype none
module aas_ctrl import aas_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_cmd_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  state_e     state_q, state_d;
  logic [2:0] sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = (in_cmd_i == CmdWrite) ? ST_OUT : ST_CHECK;
      end
      ST_CHECK: begin
        sel_d   = DivYs;
        state_d = sts_i.outside ? ST_OUT : ST_DIV_GO;
      end
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          if (sel_q == DivXe) begin
            state_d = ST_ROW_MUL;
          end else if (sel_q == DivBlu) begin
            state_d = ST_OUT;
          end else begin
            sel_d   = sel_q + 1'b1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_ROW_MUL: state_d = ST_ROW_WGT;
      ST_ROW_WGT: state_d = ST_PIX_RD;
      ST_PIX_RD:  state_d = ST_PIX_WX;
      ST_PIX_WX:  state_d = ST_PIX_MW;
      ST_PIX_MW:  state_d = ST_PIX_ACC;
      ST_PIX_ACC: begin
        if (sts_i.x_last && sts_i.y_last) begin
          sel_d   = DivRed;
          state_d = ST_DIV_GO;
        end else if (sts_i.x_last) begin
          state_d = ST_ROW_MUL;
        end else begin
          state_d = ST_PIX_RD;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.op      = DP_NONE;
    ctl_o.div_sel = sel_q;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) ctl_o.op = DP_LOAD_IN;
      end
      ST_DIV_GO:   ctl_o.op = DP_DIV_START;
      ST_DIV_WAIT: if (!sts_i.div_busy) ctl_o.op = DP_DIV_TAKE;
      ST_ROW_MUL:  ctl_o.op = DP_ROW_MUL;
      ST_ROW_WGT:  ctl_o.op = DP_ROW_WGT;
      ST_PIX_RD:   ctl_o.op = DP_PIX_RD;
      ST_PIX_WX:   ctl_o.op = DP_PIX_WX;
      ST_PIX_MW:   ctl_o.op = DP_PIX_MW;
      ST_PIX_ACC:  ctl_o.op = DP_PIX_ACC;
      ST_OUT:      if (sts_i.out_free) ctl_o.op = DP_OUT_LOAD;
      default:     ctl_o.op = DP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= DivYs;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/area_average_image_scaler_unit.sv
// Top level of the area-averaging image scaler: controller plus datapath.
// Depends on aas_pkg, aas_ctrl, aas_dp and aas_div.
`default_nettype none
// The unit keeps a 256 x 256 RGB source frame and produces area-averaged
// output pixels one at a time. A word with tuser 0 writes one source pixel
// and is acknowledged with a zero result word of kind 0. A word with tuser 1
// names an output pixel; the unit walks every source pixel the output cell
// covers, weights it by its exact overlap, and divides each channel sum by
// the cell area, truncating and saturating to a byte. A compute runs the four
// bound divisions, a row multiply and row weight step per covered source row,
// a read, x-weight, weight multiply and accumulate step per covered source
// pixel (the single frame-store read port and the weight multiply chain), and
// the three channel divisions in the shared bit-serial divider. A compute
// outside the target size returns zeros. One word is worked on at a time; a
// finished result waits in the output register, while the next word is
// already accepted. Frame contents are undefined until written, and
// configuration must be written only while idle.
module area_average_image_scaler_unit import aas_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [39:0]     s_axis_tdata,  // row_index, col_index, in_red, in_green, in_blue
  input  wire logic            s_axis_tuser,  // cmd
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // out_red, out_green, out_blue
  output logic                 m_axis_tuser   // result_kind
);

  ctl_t ctl;
  sts_t sts;

  aas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  aas_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// File: test/tb_area_average_image_scaler_unit.sv
// Self-checking testbench for area_average_image_scaler_unit: frame-store
// writes and area-averaged computes, checked against an in-bench predictor.
// Depends on aas_pkg and the RTL of the scaler unit.
`timescale 1ns / 100ps
module tb_area_average_image_scaler_unit import aas_pkg::*; ();

  // One input word and one result word, as the predictor sees them.
  typedef struct packed {
    logic       cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_res_t;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned TotalItems = 1750;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = RegSrcRows;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [39:0]     s_axis_tdata = '0;  // row_index, col_index, in_red, in_green, in_blue
  logic            s_axis_tuser = 1'b0;  // cmd
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [23:0]     m_axis_tdata;  // out_red, out_green, out_blue
  logic            m_axis_tuser;  // result_kind

  area_average_image_scaler_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the frame store and of the four size registers.
  logic [23:0]     frame_mirror [0:MaxRows*MaxCols-1];
  logic [CfgW-1:0] size_regs [0:3];

  pixel_cmd_t pending_words[$];
  pixel_res_t expected_pixels[$];

  int unsigned sent_words = 0;
  int unsigned got_results = 0;
  int unsigned compute_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 69;
  bit          hold_send = 1'b0;
  bit          word_taken = 1'b0;

  // A size register of 0 behaves as 1; larger values saturate at the limit.
  function automatic longint eff_size(logic [CfgW-1:0] v, longint limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return longint'(v);
  endfunction

  // Overlap of source pixel p with output cell k, in 1/dst pixel units.
  function automatic longint span_overlap(longint p, longint k, longint src, longint dst);
    longint lo, hi;
    lo = (p * dst > src * k) ? p * dst : src * k;
    hi = ((p + 1) * dst < src * (k + 1)) ? (p + 1) * dst : src * (k + 1);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Weighted sum of all source pixels under one output cell, divided by the
  // cell area and saturated to a byte per channel.
  function automatic pixel_res_t average_cell(longint row, longint col);
    longint     sr, sc, tr, tc, ys, ye, xs, xe, wy, wx, q;
    longint     acc [3];
    logic [23:0] px;
    pixel_res_t res;
    res = '0;
    res.kind = CmdCompute;
    sr = eff_size(size_regs[RegSrcRows], MaxRows);
    sc = eff_size(size_regs[RegSrcCols], MaxCols);
    tr = eff_size(size_regs[RegDstRows], 511);
    tc = eff_size(size_regs[RegDstCols], 511);
    if (row >= tr || col >= tc) return res;
    ys = (sr * row) / tr;
    ye = (sr * (row + 1) + tr - 1) / tr;
    xs = (sc * col) / tc;
    xe = (sc * (col + 1) + tc - 1) / tc;
    if (ye > sr) ye = sr;
    if (xe > sc) xe = sc;
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    for (longint y = ys; y < ye; y++) begin
      wy = span_overlap(y, row, sr, tr);
      if (wy != 0) begin
        for (longint x = xs; x < xe; x++) begin
          wx = span_overlap(x, col, sc, tc);
          if (wx != 0) begin
            px = frame_mirror[y * MaxCols + x];
            for (int c = 0; c < 3; c++) acc[c] += wy * wx * longint'(px[8*c +: 8]);
          end
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      q = acc[c] / (sr * sc);
      if (q > 255) q = 255;
      case (c)
        0: res.red = q[7:0];
        1: res.green = q[7:0];
        default: res.blue = q[7:0];
      endcase
    end
    return res;
  endfunction

  // Queues a word and its predicted result; the mirror is updated in queue
  // order, which is also the order in which the unit accepts the words.
  task automatic queue_word(logic cmd, int row, int col, logic [23:0] rgb);
    pixel_cmd_t w;
    pixel_res_t r;
    w = {cmd, row[7:0], col[7:0], rgb[7:0], rgb[15:8], rgb[23:16]};
    r = '0;
    if (cmd == CmdWrite) begin
      frame_mirror[row * MaxCols + col] = rgb;
      r.kind = CmdWrite;
    end else begin
      r = average_cell(row, col);
      compute_count++;
    end
    pending_words.push_back(w);
    expected_pixels.push_back(r);
  endtask

  // Waits until the unit has drained, then writes all four size registers.
  task automatic set_sizes(int sr, int sc, int tr, int tc);
    int vals [4];
    vals = '{sr, sc, tr, tc};
    wait (pending_words.size() == 0 && expected_pixels.size() == 0);
    hold_send = 1'b1;
    repeat (4) @(negedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[1:0];
      cfg_data_i <= vals[i][CfgW-1:0];
      size_regs[i] = vals[i][CfgW-1:0];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    hold_send = 1'b0;
  endtask

  // Writes every pixel of the active source area, so computes never read an
  // entry that was never written.
  task automatic fill_source(bit extremes);
    longint sr, sc;
    logic [23:0] rgb;
    sr = eff_size(size_regs[RegSrcRows], MaxRows);
    sc = eff_size(size_regs[RegSrcCols], MaxCols);
    for (int y = 0; y < sr; y++) begin
      for (int x = 0; x < sc; x++) begin
        rgb = extremes ? (((x + y) % 2) ? 24'hFFFFFF : 24'h000000) : 24'($urandom);
        queue_word(CmdWrite, y, x, rgb);
      end
    end
  endtask

  // Random mix: mostly in-range computes, some outside the target, and
  // rewrites anywhere in the store.
  task automatic random_traffic(int n);
    longint sr, sc, tr, tc;
    int unsigned pick;
    sr = eff_size(size_regs[RegSrcRows], MaxRows);
    sc = eff_size(size_regs[RegSrcCols], MaxCols);
    tr = eff_size(size_regs[RegDstRows], 511);
    tc = eff_size(size_regs[RegDstCols], 511);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        queue_word(CmdCompute, $urandom_range(0, (tr > 256 ? 256 : tr) - 1),
                   $urandom_range(0, (tc > 256 ? 256 : tc) - 1), 24'($urandom));
      end else if (pick < 80) begin
        queue_word(CmdCompute, (tr <= 255) ? $urandom_range(tr, 255) : $urandom_range(0, 255),
                   $urandom_range(0, 255), 24'($urandom));
      end else if (pick < 90) begin
        queue_word(CmdWrite, $urandom_range(0, sr - 1), $urandom_range(0, sc - 1), 24'($urandom));
      end else begin
        queue_word(CmdWrite, $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
      end
    end
  endtask

  // Capture the handshake at the rising edge; the driver reacts at the
  // falling edge, so no decision depends on event order within a step.
  always @(posedge clk_i) begin
    word_taken <= s_axis_tvalid && s_axis_tready;
  end

  // Driver: the word on the bus stays put until taken; otherwise a new word
  // is offered unless the sender idles or is held for a register write.
  always @(negedge clk_i) begin
    pixel_cmd_t w;
    bit         keep;
    if (word_taken) begin
      void'(pending_words.pop_front());
      sent_words++;
    end
    keep = s_axis_tvalid && !word_taken;
    if (!keep) begin
      if (pending_words.size() != 0 && !hold_send && rst_ni &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        w = pending_words[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= w.cmd;
        s_axis_tdata <= {w.blue, w.green, w.red, w.col, w.row};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: each result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_res_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_pixels.size());
      $display("** area_average_image_scaler_unit: FAILED **");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_results++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word kind=%0b data=%h",
                                       m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.red ||
            m_axis_tdata[15:8] !== want.green || m_axis_tdata[23:16] !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected kind=%0b rgb=%h_%h_%h, got kind=%0b rgb=%h_%h_%h",
                     got_results, want.kind, want.red, want.green, want.blue, m_axis_tuser,
                     m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]);
        end
      end
    end
  end

  // Idle profile changes with progress: sender rarely idle first, then the
  // receiver rarely idle, then back-to-back traffic on both sides.
  always @(posedge clk_i) begin
    if (sent_words > 1200) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (sent_words > 600) begin
      send_idle_pct = 69;
      recv_idle_pct = 8;
    end
  end

  initial begin
    size_regs[RegSrcRows] = 9'd256;
    size_regs[RegSrcCols] = 9'd256;
    size_regs[RegDstRows] = 9'd128;
    size_regs[RegDstCols] = 9'd128;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero-size registers all act as one pixel; computes outside the
    // one-pixel target return zeros.
    set_sizes(0, 0, 0, 0);
    queue_word(CmdWrite, 0, 0, 24'hFFFFFF);
    queue_word(CmdCompute, 0, 0, 24'hFFFFFF);
    queue_word(CmdCompute, 1, 0, 24'h0);
    queue_word(CmdCompute, 0, 255, 24'h0);
    queue_word(CmdWrite, 255, 255, 24'hFFFFFF);
    queue_word(CmdCompute, 255, 255, 24'hFFFFFF);

    // Oversize source rows saturate at the store height: a tall, narrow
    // frame collapsed into one row of two output pixels.
    set_sizes(300, 2, 1, 2);
    fill_source(1'b1);
    queue_word(CmdCompute, 0, 0, 24'h0);
    queue_word(CmdCompute, 0, 1, 24'h0);
    queue_word(CmdCompute, 0, 2, 24'h0);

    // Full-width row, one-to-one, then full-height column.
    set_sizes(1, 256, 1, 256);
    fill_source(1'b0);
    queue_word(CmdCompute, 0, 0, 24'h0);
    queue_word(CmdCompute, 0, 255, 24'h0);
    set_sizes(256, 1, 256, 1);
    fill_source(1'b0);
    queue_word(CmdCompute, 255, 0, 24'h0);
    queue_word(CmdCompute, 0, 0, 24'h0);

    // Upscaling with targets beyond the byte-wide index range.
    set_sizes(3, 3, 300, 511);
    fill_source(1'b1);
    queue_word(CmdCompute, 255, 255, 24'h0);
    queue_word(CmdCompute, 0, 0, 24'h0);
    queue_word(CmdCompute, 128, 77, 24'h0);

    // Random phases with small frames so compute latency stays short.
    while (sent_words + pending_words.size() < TotalItems) begin
      set_sizes($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16),
                $urandom_range(1, 16), $urandom_range(1, 20), $urandom_range(0, 20));
      fill_source(1'b0);
      random_traffic(60);
    end

    wait (pending_words.size() == 0 && expected_pixels.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d words (%0d computes) over several frame and target sizes",
             sent_words, compute_count);
    $display("%0d results checked, %0d mismatches", got_results, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("** area_average_image_scaler_unit: PASSED **");
    end else begin
      $display("** area_average_image_scaler_unit: FAILED **");
    end
    $finish;
  end

endmodule
